// ----- hw/rtl/het_pkg.sv -----
// ----------------------------------------------------------------------------
// het_pkg
// Shared beat types, codes and widths for the hysteresis edge threshold block.
// ----------------------------------------------------------------------------
package het_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // widest geometry the position counters can hold (4096 pixels per row or rows)
    localparam int POS_W      = 12;
    localparam int LAG_W      = POS_W + 2;

    localparam int WIN_SIDE   = 5;
    localparam int NUM_LINES  = WIN_SIDE - 1;
    localparam int BANK_W     = 2;

    localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

    localparam int RST_LOW    = 50;
    localparam int RST_HIGH   = 100;
    localparam int RST_WIDTH  = 640;
    localparam int RST_HEIGHT = 480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_THR    = 2'd0,
        CFG_HIGH_THR   = 2'd1,
        CFG_IMG_WIDTH  = 2'd2,
        CFG_IMG_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             flush;
        logic             frame_start;
    } t_in_beat;

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic             frame_last;
    } t_out_beat;

    // effective geometry and thresholds
    typedef struct packed {
        logic [PIX_W-1:0] low;
        logic [PIX_W-1:0] high;
        logic [POS_W-1:0] wm1;
        logic [POS_W-1:0] hm1;
        logic [LAG_W-1:0] lag;
    } t_geom;

    // per-item control from the position sequencer
    typedef struct packed {
        logic [PIX_W-1:0]    pix;
        logic                emit;
        logic                last;
        logic [BANK_W-1:0]   bank;
        logic [POS_W-1:0]    addr;
        logic [WIN_SIDE-1:0] row_ok;
        logic [WIN_SIDE-1:0] col_ok;
    } t_step;

    typedef logic [NUM_LINES-1:0][PIX_W-1:0] t_lines;

endpackage

// ----- hw/rtl/hysteresis_edge_threshold.sv -----
// pipeline: the beat that releases a result is registered in stage one and the
//   result in the output register; results trail the input by 2*width+2 positions
// throughput: one beat per cycle while the output is not stalled, set by the single-port line banks and window
// reset: thresholds and geometry to defaults, counters and valids cleared;
//   line banks and window are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
// hysteresis_edge_threshold
// Double-threshold hysteresis over a 5x5 neighborhood on a raster pixel stream.
// ----------------------------------------------------------------------------
module hysteresis_edge_threshold #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input beats
    input  logic                            i_in_valid,
    input  het_pkg::t_in_beat               i_in_data,
    output logic                            o_in_stall,
    // result beats
    output logic                            o_out_valid,
    output het_pkg::t_out_beat              o_out_data,
    input  logic                            i_out_stall,
    // register writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [het_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [het_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import het_pkg::*;

    t_geom  geom;
    t_step  step;
    t_lines rd;
    logic   accept;
    logic   take;

    // writes are always taken
    assign o_cfg_ready = 1'b1;

    het_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_idx   (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_geom  (geom)
    );

    // a beat past the end of a drained frame is accepted and dropped
    assign accept = i_in_valid && !o_in_stall;

    het_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in_data),
        .i_geom   (geom),
        .o_take   (take),
        .o_step   (step)
    );

    // line banks are read at the beat's column as the beat enters stage one,
    // so the four older rows line up with the pixel in the window stage
    het_lbuf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_lbuf (
        .i_clk   (i_clk),
        .i_en    (take),
        .i_bank  (step.bank),
        .i_addr  (step.addr),
        .i_wdata (step.pix),
        .o_rd    (rd)
    );

    // window shift, compare against thresholds, skid into the output register
    het_win u_win (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_step      (step),
        .i_rd        (rd),
        .i_geom      (geom),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out_data),
        .o_in_stall  (o_in_stall)
    );

endmodule

// ----- hw/rtl/het_cfg.sv -----
// ----------------------------------------------------------------------------
// het_cfg
// Configuration registers; geometry is clamped and stored in effective form.
// ----------------------------------------------------------------------------
module het_cfg #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr,
    input  logic [het_pkg::CFG_IDX_W-1:0]    i_idx,
    input  logic [het_pkg::CFG_DATA_W-1:0]   i_data,
    output het_pkg::t_geom                   o_geom
);
    import het_pkg::*;

    localparam int RST_W = (MAX_WIDTH < RST_WIDTH) ? MAX_WIDTH : RST_WIDTH;
    localparam int RST_H = (MAX_HEIGHT < RST_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT;

    // clamp to 1..lim, return value minus one
    function automatic logic [POS_W-1:0] dim_m1(input logic [CFG_DATA_W-1:0] d,
                                                input int lim);
        logic [LAG_W-1:0] dx;
        dx = LAG_W'(d);
        if (dx == '0) begin
            dim_m1 = '0;
        end else if (dx > LAG_W'(lim)) begin
            dim_m1 = POS_W'(lim - 1);
        end else begin
            dim_m1 = POS_W'(dx - LAG_W'(1));
        end
    endfunction

    logic [PIX_W-1:0] r_low;
    logic [PIX_W-1:0] r_high;
    logic [POS_W-1:0] r_wm1;
    logic [POS_W-1:0] r_hm1;
    logic [LAG_W-1:0] r_lag;
    logic [POS_W-1:0] n_wm1;
    logic [POS_W-1:0] n_hm1;

    assign n_wm1 = dim_m1(i_data, MAX_WIDTH);
    assign n_hm1 = dim_m1(i_data, MAX_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= PIX_W'(RST_LOW);
            r_high <= PIX_W'(RST_HIGH);
            r_wm1  <= POS_W'(RST_W - 1);
            r_hm1  <= POS_W'(RST_H - 1);
            r_lag  <= LAG_W'(2 * RST_W + 2);
        end else if (i_wr) begin
            case (t_cfg_idx'(i_idx))
                CFG_LOW_THR: begin
                    r_low <= i_data[PIX_W-1:0];
                end
                CFG_HIGH_THR: begin
                    r_high <= i_data[PIX_W-1:0];
                end
                CFG_IMG_WIDTH: begin
                    r_wm1 <= n_wm1;
                    // lag = 2*w + 2 = 2*(w-1) + 4
                    r_lag <= {1'b0, n_wm1, 1'b0} + LAG_W'(4);
                end
                CFG_IMG_HEIGHT: begin
                    r_hm1 <= n_hm1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_geom = '{low: r_low, high: r_high, wm1: r_wm1, hm1: r_hm1, lag: r_lag};

endmodule

// ----- hw/rtl/het_seq.sv -----
// ----------------------------------------------------------------------------
// het_seq
// Input and output position counters; builds per-item control for the window.
// ----------------------------------------------------------------------------
module het_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  het_pkg::t_in_beat i_in,
    input  het_pkg::t_geom    i_geom,
    output logic              o_take,
    output het_pkg::t_step    o_step
);
    import het_pkg::*;

    logic [POS_W-1:0]  r_in_col;
    logic [BANK_W-1:0] r_bank;
    logic [LAG_W-1:0]  r_pre;
    logic              r_run;
    logic              r_done;
    logic [POS_W-1:0]  r_out_col;
    logic [POS_W-1:0]  r_out_row;

    // frame start restarts every counter for this beat
    logic              fs;
    logic [POS_W-1:0]  col_e;
    logic [BANK_W-1:0] bank_e;
    logic [LAG_W-1:0]  pre_e;
    logic              run_e;
    logic              done_e;
    logic [POS_W-1:0]  ocol_e;
    logic [POS_W-1:0]  orow_e;
    logic              emit;
    logic              last;
    logic              col_wrap;
    logic              ocol_wrap;
    logic [LAG_W-1:0]  ocol_x;
    logic [LAG_W-1:0]  orow_x;
    logic [LAG_W-1:0]  wm1_x;
    logic [LAG_W-1:0]  hm1_x;

    assign fs     = i_in.frame_start;
    assign col_e  = fs ? '0 : r_in_col;
    assign bank_e = fs ? '0 : r_bank;
    assign pre_e  = fs ? '0 : r_pre;
    assign run_e  = fs ? 1'b0 : r_run;
    assign done_e = fs ? 1'b0 : r_done;
    assign ocol_e = fs ? '0 : r_out_col;
    assign orow_e = fs ? '0 : r_out_row;

    assign o_take    = i_accept && !done_e;
    assign emit      = run_e || (pre_e == i_geom.lag);
    assign ocol_wrap = (ocol_e == i_geom.wm1);
    assign last      = ocol_wrap && (orow_e == i_geom.hm1);
    assign col_wrap  = (col_e == i_geom.wm1);

    assign ocol_x = LAG_W'(ocol_e);
    assign orow_x = LAG_W'(orow_e);
    assign wm1_x  = LAG_W'(i_geom.wm1);
    assign hm1_x  = LAG_W'(i_geom.hm1);

    always_comb begin
        o_step.pix    = i_in.flush ? '0 : i_in.pixel_value;
        o_step.emit   = emit;
        o_step.last   = last;
        o_step.bank   = bank_e;
        o_step.addr   = col_e;
        // row k of the window sits 2-k rows below the center
        o_step.row_ok[0] = (orow_x + LAG_W'(2)) <= hm1_x;
        o_step.row_ok[1] = (orow_x + LAG_W'(1)) <= hm1_x;
        o_step.row_ok[2] = 1'b1;
        o_step.row_ok[3] = orow_x >= LAG_W'(1);
        o_step.row_ok[4] = orow_x >= LAG_W'(2);
        o_step.col_ok[0] = (ocol_x + LAG_W'(2)) <= wm1_x;
        o_step.col_ok[1] = (ocol_x + LAG_W'(1)) <= wm1_x;
        o_step.col_ok[2] = 1'b1;
        o_step.col_ok[3] = ocol_x >= LAG_W'(1);
        o_step.col_ok[4] = ocol_x >= LAG_W'(2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_bank    <= '0;
            r_pre     <= '0;
            r_run     <= 1'b0;
            r_done    <= 1'b0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (o_take) begin
            r_in_col <= col_wrap ? '0 : col_e + POS_W'(1);
            r_bank   <= col_wrap ? bank_e + BANK_W'(1) : bank_e;
            r_pre    <= emit ? pre_e : pre_e + LAG_W'(1);
            r_run    <= emit;
            if (emit) begin
                r_out_col <= ocol_wrap ? '0 : ocol_e + POS_W'(1);
                r_out_row <= ocol_wrap ? orow_e + POS_W'(1) : orow_e;
                r_done    <= last;
            end else begin
                r_out_col <= ocol_e;
                r_out_row <= orow_e;
                r_done    <= done_e;
            end
        end
    end

endmodule

// ----- hw/rtl/het_lbuf.sv -----
// ----------------------------------------------------------------------------
// het_lbuf
// Four line banks, one per row modulo four, read-first with registered data.
// ----------------------------------------------------------------------------
module het_lbuf #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [het_pkg::BANK_W-1:0]    i_bank,
    input  logic [het_pkg::POS_W-1:0]     i_addr,
    input  logic [het_pkg::PIX_W-1:0]     i_wdata,
    output het_pkg::t_lines               o_rd
);
    import het_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [AW-1:0] addr;

    assign addr = i_addr[AW-1:0];

    for (genvar b = 0; b < NUM_LINES; b++) begin : g_bank
        logic [PIX_W-1:0] mem [MAX_WIDTH];
        logic [PIX_W-1:0] r_rd;

        // the bank of the current row returns the row four back before overwrite
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (i_bank == BANK_W'(b)) begin
                    mem[addr] <= i_wdata;
                end
                r_rd <= mem[addr];
            end
        end

        assign o_rd[b] = r_rd;
    end

endmodule

// ----- hw/rtl/het_win.sv -----
// ----------------------------------------------------------------------------
// het_win
// 5x5 window, threshold classification and output register.
// ----------------------------------------------------------------------------
module het_win (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  het_pkg::t_step     i_step,
    input  het_pkg::t_lines    i_rd,
    input  het_pkg::t_geom     i_geom,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output het_pkg::t_out_beat o_out,
    output logic               o_in_stall
);
    import het_pkg::*;

    logic                                          r_s1_valid;
    t_step                                         r_s1;
    logic [WIN_SIDE-1:0][WIN_SIDE-2:0][PIX_W-1:0]  r_win;
    logic                                          r_out_valid;
    t_out_beat                                     r_out;

    logic [WIN_SIDE-1:0][WIN_SIDE-1:0][PIX_W-1:0]  tap;
    logic [WIN_SIDE-1:0][PIX_W-1:0]                col0;
    logic [PIX_W-1:0]                              centre;
    logic                                          has_strong;
    logic [PIX_W-1:0]                              result;
    logic                                          s1_adv;

    always_comb begin
        logic [BANK_W-1:0] sel;
        sel = '0;
        for (int k = 0; k < WIN_SIDE; k++) begin
            if (k == 0) begin
                col0[k] = r_s1.pix;
            end else begin
                // row k back lives in bank (row - k) mod 4
                sel     = r_s1.bank - BANK_W'(k);
                col0[k] = i_rd[sel];
            end
            tap[k][0] = col0[k];
            for (int j = 1; j < WIN_SIDE; j++) begin
                tap[k][j] = r_win[k][j-1];
            end
        end
    end

    assign centre = tap[WIN_SIDE/2][WIN_SIDE/2];

    always_comb begin
        has_strong = 1'b0;
        for (int k = 0; k < WIN_SIDE; k++) begin
            for (int j = 0; j < WIN_SIDE; j++) begin
                if (r_s1.row_ok[k] && r_s1.col_ok[j] && (tap[k][j] > i_geom.high)) begin
                    has_strong = 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (centre > i_geom.high) begin
            result = EDGE_ON;
        end else if (centre < i_geom.low) begin
            result = EDGE_OFF;
        end else begin
            result = has_strong ? EDGE_ON : EDGE_OFF;
        end
    end

    assign s1_adv     = r_s1_valid && (!r_s1.emit || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv && r_s1.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_s1 <= i_step;
        end
        if (s1_adv) begin
            for (int k = 0; k < WIN_SIDE; k++) begin
                r_win[k][0] <= col0[k];
                for (int j = 1; j < WIN_SIDE - 1; j++) begin
                    r_win[k][j] <= r_win[k][j-1];
                end
            end
            if (r_s1.emit) begin
                r_out.edge_value <= result;
                r_out.frame_last <= r_s1.last;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
